>>> rtl/angle_bias_kalman_filter_core_macros.svh
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core_macros
// assertion macros for the angle and bias filter core
// ----------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`ifndef SYNTH
`define ABK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ABK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ABK_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ABK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// shared types and constants of the angle and bias filter
// ----------------------------------------------------------------------------
package abkf_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd66;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd197;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd1966;

  // sample word: first field sits at the top of the packed payload
  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic [20:0]        time_step;
  } sample_word_t;

  // estimate word
  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] corrected_rate;
  } estimate_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_M_ANG, ST_ANG, ST_M_P11, ST_INNER, ST_M_P00,
    ST_P00, ST_M_P11N, ST_PREDC, ST_S, ST_DIV0, ST_GAIN0, ST_DIV1,
    ST_GAIN1, ST_Y, ST_M_K0Y, ST_A0, ST_M_K1Y, ST_A1, ST_M_K0P00,
    ST_C0, ST_M_K0P01, ST_C1, ST_M_K1P00, ST_C2, ST_M_K1P01, ST_C3, ST_OUT
  } state_t;

  // one datapath step per controller state
  typedef struct packed {
    state_t step;
    logic   div_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

>>> rtl/abkf_if.sv
// ----------------------------------------------------------------------------
// abkf_if
// valid and ready channel carrying a payload word
// ----------------------------------------------------------------------------
interface abkf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/abkf_ctrl.sv
// ----------------------------------------------------------------------------
// abkf_ctrl
// sequencer stepping the datapath through one filter update
// ----------------------------------------------------------------------------
module abkf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_load,
  input  logic            out_busy,
  output abkf_pkg::cmd_t  cmd,
  input  abkf_pkg::stat_t stat
);
  import abkf_pkg::*;
  `include "angle_bias_kalman_filter_core_macros.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.step = state;
    cmd.div_start = 1'b0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_RATE;
      end
      ST_S: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV0;
      end
      ST_DIV0: if (stat.div_done) state_next = ST_GAIN0;
      ST_GAIN0: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV1;
      end
      ST_DIV1: if (stat.div_done) state_next = ST_GAIN1;
      ST_OUT: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = state_t'(state + 5'd1);
    endcase
  end

  `ABK_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == ST_IDLE)
  `ABK_ASSERT_NEXT(a_accept_go, clk, rst, in_ready && in_valid, state == ST_RATE)
  `ABK_ASSERT_IMPL(a_load_out, clk, rst, out_load, state == ST_OUT && !out_busy)
endmodule

>>> rtl/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// radix-2 restoring divider, signed, truncating, saturated to 32 bits
// ----------------------------------------------------------------------------
module abkf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import abkf_pkg::*;
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [NW:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic          neg, busy, zero;
  logic [NW:0]   trial;

  assign trial = {rem[NW-1:0], dvd[NW-1]} - {{(NW-31){1'b0}}, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        rem <= '0;
        dvd <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
        dvs <= den[31] ? 32'(-den) : 32'(den);
        neg <= num[31] ^ den[31];
        zero <= (den == 32'sd0);
      end else if (busy) begin
        if (!trial[NW]) rem <= trial;
        else rem <= {rem[NW-1:0], dvd[NW-1]};
        dvd <= {dvd[NW-2:0], ~trial[NW]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  logic signed [65:0] q;
  always_comb begin
    q = neg ? -$signed({1'b0, 65'(dvd)}) : $signed({1'b0, 65'(dvd)});
    quo = zero ? 32'sd0 : sat32(q);
  end
endmodule

>>> rtl/abkf_dp.sv
// ----------------------------------------------------------------------------
// abkf_dp
// filter state registers, one shared multiplier and the adders
// ----------------------------------------------------------------------------
module abkf_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  abkf_pkg::cmd_t     cmd,
  output abkf_pkg::stat_t    stat,
  input  logic               load_in,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  input  logic [20:0]        time_step,
  input  logic [30:0]        angle_noise,
  input  logic [30:0]        bias_noise,
  input  logic [30:0]        meas_noise,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] corrected_rate
);
  import abkf_pkg::*;

  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] m_ang, m_rate, rate, dtp11, inner, s, k0, k1, y, op00, op01;
  logic signed [31:0] prod;
  logic [20:0]        dt;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mfull;
  logic signed [65:0] rnd;
  logic signed [31:0] quo;
  logic               div_done;
  logic signed [31:0] div_num;

  assign stat.div_done = div_done;
  assign div_num = (cmd.step == ST_S) ? p00 : p10;

  // innovation variance, p00 holds still from prediction until the gains are taken
  assign s = sat32(66'(p00) + 66'($signed({1'b0, meas_noise})));

  abkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(s),
    .done(div_done), .quo(quo)
  );

  // multiplier operand select
  always_comb begin
    ma = k0;
    mb = y;
    case (cmd.step)
      ST_M_ANG:   begin ma = $signed({11'd0, dt}); mb = rate; end
      ST_M_P11:   begin ma = $signed({11'd0, dt}); mb = p11; end
      ST_M_P00:   begin ma = $signed({11'd0, dt}); mb = inner; end
      ST_M_P11N:  begin ma = $signed({1'b0, bias_noise}); mb = $signed({11'd0, dt}); end
      ST_M_K0Y:   begin ma = k0; mb = y; end
      ST_M_K1Y:   begin ma = k1; mb = y; end
      ST_M_K0P00: begin ma = k0; mb = op00; end
      ST_M_K0P01: begin ma = k0; mb = op01; end
      ST_M_K1P00: begin ma = k1; mb = op00; end
      ST_M_K1P01: begin ma = k1; mb = op01; end
      default:    begin ma = k0; mb = y; end
    endcase
    mfull = ma * mb;
    rnd = ($signed({{2{mfull[63]}}, mfull}) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang <= '0; bias <= '0; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
    end else begin
      case (cmd.step)
        ST_RATE:  rate <= sat32(66'(m_rate) - 66'(bias));
        ST_ANG:   ang <= sat32(66'(ang) + 66'(prod));
        ST_M_P11: ;
        ST_INNER: begin
          dtp11 <= prod;
          inner <= sat32(66'(prod) - 66'(p01) - 66'(p10) + 66'($signed({1'b0, angle_noise})));
        end
        ST_P00:   begin
          p00 <= sat32(66'(p00) + 66'(prod));
          p01 <= sat32(66'(p01) - 66'(dtp11));
          p10 <= sat32(66'(p10) - 66'(dtp11));
        end
        ST_PREDC: p11 <= sat32(66'(p11) + 66'(prod));
        ST_GAIN0: k0 <= quo;
        ST_GAIN1: k1 <= quo;
        ST_Y:     begin
          y <= sat32(66'(m_ang) - 66'(ang));
          op00 <= p00;
          op01 <= p01;
        end
        ST_A0:    ang <= sat32(66'(ang) + 66'(prod));
        ST_A1:    bias <= sat32(66'(bias) + 66'(prod));
        ST_C0:    p00 <= sat32(66'(p00) - 66'(prod));
        ST_C1:    p01 <= sat32(66'(p01) - 66'(prod));
        ST_C2:    p10 <= sat32(66'(p10) - 66'(prod));
        ST_C3:    p11 <= sat32(66'(p11) - 66'(prod));
        default:  ;
      endcase
    end
  end

  // registered product and input capture
  always_ff @(posedge clk) begin
    prod <= sat32(rnd);
    if (load_in) begin
      m_ang <= measured_angle;
      m_rate <= measured_rate;
      dt <= time_step;
    end
  end

  assign angle_estimate = ang;
  assign corrected_rate = rate;
endmodule

>>> rtl/angle_bias_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// two-state angle and gyro bias filter, signed fixed point, saturating
// ----------------------------------------------------------------------------
// channel  dir  word
// in_ch    in   measured_angle, measured_rate, time_step
// out_ch   out  angle_estimate, corrected_rate
// cfg      in   cfg_we, cfg_index, cfg_data
//
// one word runs from acceptance to the next ready through two serial
// divides of 32+FRAC_BITS steps each, plus the sequencer states around
// the shared multiplier
// one word in flight; the next is taken once the result sits in the
// output register, so a stalled sink holds the block only past that point
// reset is synchronous: state and covariance clear, noise registers reload
module angle_bias_kalman_filter_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  abkf_if.sink        in_ch,
  abkf_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [30:0] cfg_data
);
  import abkf_pkg::*;
  `include "angle_bias_kalman_filter_core_macros.svh"

  logic [30:0] angle_noise, bias_noise, meas_noise;
  cmd_t        cmd;
  stat_t       stat;
  logic        in_ready, out_load, load_in;
  logic signed [31:0] ang_est, cor_rate;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise <= BIAS_NOISE_RST;
      meas_noise <= MEAS_NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_BIAS_NOISE:  bias_noise <= cfg_data;
        REG_MEAS_NOISE:  meas_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign load_in = in_ready && in_ch.valid;

  abkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_load(out_load), .out_busy(out_ch.valid && !out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  abkf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .load_in(load_in),
    .measured_angle(in_ch.data.measured_angle),
    .measured_rate(in_ch.data.measured_rate),
    .time_step(in_ch.data.time_step),
    .angle_noise(angle_noise), .bias_noise(bias_noise), .meas_noise(meas_noise),
    .angle_estimate(ang_est), .corrected_rate(cor_rate)
  );

  // output register, freed when the sink takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.data.angle_estimate <= ang_est;
      out_ch.data.corrected_rate <= cor_rate;
    end
  end

  `ABK_ASSERT_NEXT(a_out_set, clk, rst, out_load, out_ch.valid)
  `ABK_ASSERT_IMPL(a_no_overrun, clk, rst, out_load, !(out_ch.valid && !out_ch.ready))
  `ABK_ASSERT_IMPL(a_one_side, clk, rst, out_load, !in_ch.ready)
endmodule
